>>> rtl/pvd_pkg.sv
// Package with the shared types, widths and codes of the pairwise vector distance block.
`default_nettype none
package pvd_pkg;

	// Row length limit and accumulator widths.
	localparam int MAX_COLUMNS = 4096;
	localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
	localparam int SUM_W       = 44;
	localparam int ABS_W       = 29;
	localparam int SQD_W       = 45;
	localparam int RATIO_W     = 30;
	localparam int DIST_W      = 48;
	localparam int RES_W       = DIST_W + 1;

	// Shared arithmetic units.
	localparam int MUL_W   = 22;
	localparam int DIV_N_W = 76;
	localparam int DIV_D_W = 43;
	localparam int DIV_S_W = 7;
	localparam int SQ_X_W  = 86;
	localparam int SQ_R_W  = SQ_X_W / 2;
	localparam int SQ_S_W  = $clog2(SQ_R_W + 1);

	// Numerator lengths of two divisions and the numerator shift of the chord division.
	localparam int RATIO_NUM_W = 34;
	localparam int CANB_NUM_W  = 31;
	localparam int CHORD_SHIFT = 33;

	localparam logic [RES_W-1:0] DIST_MAX = {1'b0, {DIST_W{1'b1}}};

	// Metric register codes.
	typedef logic [1:0] metric_t;
	localparam metric_t METRIC_CHORD     = 2'd0;
	localparam metric_t METRIC_CANBERRA  = 2'd1;
	localparam metric_t METRIC_MANHATTAN = 2'd2;
	localparam metric_t METRIC_EUCLIDEAN = 2'd3;

	// One classified element pair as it waits in the queue.
	typedef struct packed {
		logic [15:0] a_mag;
		logic [15:0] b_mag;
		logic [15:0] adev;
		logic [16:0] den;
		logic        prod_neg;
		logic        usable;
		logic        nonzero;
		logic        last;
	} item_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_RATIO,
		ST_FINAL,
		ST_CH_MUL,
		ST_CH_SQ,
		ST_CH_ROOT,
		ST_CH_DV,
		ST_CH_DIV,
		ST_CH_LAST,
		ST_CH_FIN,
		ST_EU_ROOT,
		ST_CB_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> rtl/pvd_front.sv
// Front end: classifies incoming element pairs and queues them for the back end.
`default_nettype none
module pvd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [15:0]  value_a,
	input  wire logic [15:0]  value_b,
	input  wire logic         a_missing,
	input  wire logic         b_missing,
	input  wire logic         last_element,
	output logic              item_valid,
	output pvd_pkg::item_t    item,
	input  wire logic         item_pop
);
	import pvd_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     fill_q;
	item_t              cls;
	logic signed [16:0] a_ext;
	logic signed [16:0] b_ext;
	logic signed [16:0] diff;
	logic               push;
	logic               pop;

	// Classify the pair: magnitudes, difference and Canberra denominator.
	always_comb begin
		a_ext        = {value_a[15], value_a};
		b_ext        = {value_b[15], value_b};
		diff         = a_ext - b_ext;
		cls.a_mag    = value_a[15] ? 16'(-a_ext) : value_a;
		cls.b_mag    = value_b[15] ? 16'(-b_ext) : value_b;
		cls.adev     = diff[16] ? 16'(-diff) : diff[15:0];
		cls.den      = {1'b0, cls.a_mag} + {1'b0, cls.b_mag};
		cls.prod_neg = value_a[15] ^ value_b[15];
		cls.usable   = !a_missing && !b_missing;
		cls.nonzero  = (value_a != 16'd0) || (value_b != 16'd0);
		cls.last     = last_element;
	end

	assign in_stall   = (fill_q == (PTR_W+1)'(DEPTH));
	assign push       = in_valid && !in_stall;
	assign item_valid = (fill_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

>>> rtl/pvd_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module pvd_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [pvd_pkg::DIV_N_W-1:0]   num,
	input  wire logic [pvd_pkg::DIV_D_W-1:0]   den,
	input  wire logic [pvd_pkg::DIV_S_W-1:0]   steps,
	output logic                               done,
	output logic [pvd_pkg::DIV_N_W-1:0]        quot
);
	import pvd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_S_W-1:0]   cnt_q;
	logic [DIV_N_W-1:0]   num_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quot_q;
	logic [DIV_D_W:0]     trial;
	logic                 fits;

	// One compare and subtract per step; the numerator is left aligned.
	always_comb begin
		trial = {rem_q, num_q[DIV_N_W-1]};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_N_W-2:0], 1'b0};
			rem_q  <= fits ? DIV_D_W'(trial - {1'b0, den_q}) : trial[DIV_D_W-1:0];
			quot_q <= {quot_q[DIV_N_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_S_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_S_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

>>> rtl/pvd_sqrt.sv
// Digit-recurrence square root, one root bit per cycle, rounded to nearest.
`default_nettype none
module pvd_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pvd_pkg::SQ_X_W-1:0]  x,
	output logic                             done,
	output logic [pvd_pkg::SQ_R_W:0]         root
);
	import pvd_pkg::*;

	localparam int REM_W = SQ_R_W + 4;

	logic                busy_q;
	logic                done_q;
	logic [SQ_S_W-1:0]   cnt_q;
	logic [SQ_X_W-1:0]   x_q;
	logic [REM_W-1:0]    rem_q;
	logic [SQ_R_W-1:0]   root_q;
	logic [REM_W-1:0]    nrem;
	logic [REM_W-1:0]    trial;
	logic                fits;

	// Bring down two bits and try appending a one to the root.
	always_comb begin
		nrem  = {rem_q[REM_W-3:0], x_q[SQ_X_W-1 -: 2]};
		trial = REM_W'({root_q, 2'b01});
		fits  = (nrem >= trial);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SQ_X_W-3:0], 2'b00};
			rem_q  <= fits ? nrem - trial : nrem;
			root_q <= {root_q[SQ_R_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == SQ_S_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_S_W'(SQ_R_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_S_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Round up when the remainder exceeds the root, that is x > r*(r+1).
	assign done = done_q;
	assign root = (rem_q > REM_W'(root_q)) ? {1'b0, root_q} + 1'b1 : {1'b0, root_q};

endmodule
`default_nettype wire

>>> rtl/pvd_back.sv
// Back end: accumulates queued pairs and computes the distance at the end of a row pair.
`default_nettype none
module pvd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pvd_pkg::metric_t            metric,
	input  wire logic                        item_valid,
	input  wire pvd_pkg::item_t              item,
	output logic                             item_pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [pvd_pkg::DIST_W-1:0]       distance,
	output logic                             invalid,
	output logic                             saturated
);
	import pvd_pkg::*;

	state_t                    state_q;
	state_t                    state_d;
	item_t                     item_q;
	logic [2:0]                k_q;
	logic signed [SUM_W-1:0]   cross_q;
	logic [SUM_W-1:0]          sqa_q;
	logic [SUM_W-1:0]          sqb_q;
	logic [ABS_W-1:0]          abs_q;
	logic [SQD_W-1:0]          sqd_q;
	logic [RATIO_W-1:0]        ratio_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [2*MUL_W-1:0]        mul_q;
	logic [SQ_X_W-1:0]         prod_q;
	logic [SQ_R_W:0]           r_q;
	logic [DIV_N_W-1:0]        t_q;
	logic [RES_W-1:0]          res_q;
	logic                      res_inv_q;
	logic                      out_valid_q;
	logic [DIST_W-1:0]         dist_q;
	logic                      inv_q;
	logic                      sat_q;

	logic [MUL_W-1:0]          mul_a;
	logic [MUL_W-1:0]          mul_b;
	logic                      used;
	logic                      out_free;
	logic                      div_go;
	logic [DIV_N_W-1:0]        div_num;
	logic [DIV_D_W-1:0]        div_den;
	logic [DIV_S_W-1:0]        div_steps;
	logic                      div_done;
	logic [DIV_N_W-1:0]        div_quot;
	logic                      sq_go;
	logic [SQ_X_W-1:0]         sq_x;
	logic                      sq_done;
	logic [SQ_R_W:0]           sq_root;
	logic [SUM_W-2:0]          cross_mag;
	logic [RATIO_NUM_W-1:0]    ratio_num;
	logic [CANB_NUM_W-1:0]     canb_num;
	logic [DIV_N_W-1:0]        chord_num;
	logic [DIV_N_W-1:0]        chord_d;
	logic [DIV_N_W-1:0]        unit_t;

	pvd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.done   (div_done),
		.quot   (div_quot)
	);

	pvd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_go),
		.x      (sq_x),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Operand values for the shared divider and root unit.
	always_comb begin
		used      = item.usable && ((metric != METRIC_CANBERRA) || item.nonzero)
		            && (cnt_q < CNT_W'(MAX_COLUMNS));
		out_free  = !out_valid_q || !out_stall;
		cross_mag = cross_q[SUM_W-1] ? (SUM_W-1)'(-cross_q) : cross_q[SUM_W-2:0];
		ratio_num = RATIO_NUM_W'({item_q.adev, 16'd0}) + RATIO_NUM_W'(item_q.den >> 1);
		canb_num  = CANB_NUM_W'(ratio_q) + CANB_NUM_W'(cnt_q >> 1);
		chord_num = DIV_N_W'({cross_mag, CHORD_SHIFT'(0)}) + DIV_N_W'(r_q >> 1);
		unit_t    = DIV_N_W'(1) << CHORD_SHIFT;
		if (cross_q[SUM_W-1]) begin
			chord_d = unit_t + t_q;
		end else if (t_q >= unit_t) begin
			chord_d = '0;
		end else begin
			chord_d = unit_t - t_q;
		end
	end

	// Shared multiplier operands: pair products, or partial products of the norms.
	always_comb begin
		if (state_q == ST_CH_MUL) begin
			unique case (k_q[2:1])
				2'd0: begin mul_a = sqa_q[MUL_W-1:0];     mul_b = sqb_q[MUL_W-1:0];     end
				2'd1: begin mul_a = sqa_q[MUL_W-1:0];     mul_b = sqb_q[SUM_W-1:MUL_W]; end
				2'd2: begin mul_a = sqa_q[SUM_W-1:MUL_W]; mul_b = sqb_q[MUL_W-1:0];     end
				default: begin mul_a = sqa_q[SUM_W-1:MUL_W]; mul_b = sqb_q[SUM_W-1:MUL_W]; end
			endcase
		end else begin
			unique case (k_q[2:1])
				2'd0: begin mul_a = MUL_W'(item_q.a_mag); mul_b = MUL_W'(item_q.b_mag); end
				2'd1: begin mul_a = MUL_W'(item_q.a_mag); mul_b = MUL_W'(item_q.a_mag); end
				2'd2: begin mul_a = MUL_W'(item_q.b_mag); mul_b = MUL_W'(item_q.b_mag); end
				default: begin mul_a = MUL_W'(item_q.adev); mul_b = MUL_W'(item_q.adev); end
			endcase
		end
	end

	// Sequencer: next state and unit start requests.
	always_comb begin
		state_d   = state_q;
		item_pop  = 1'b0;
		div_go    = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_steps = '0;
		sq_go     = 1'b0;
		sq_x      = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_pop = item_valid;
				if (item_valid) begin
					if (used) begin
						state_d = ST_PROD;
					end else if (item.last) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_PROD: begin
				if (k_q == 3'd7) begin
					if (item_q.nonzero) begin
						div_go    = 1'b1;
						div_num   = {ratio_num, (DIV_N_W-RATIO_NUM_W)'(0)};
						div_den   = DIV_D_W'(item_q.den);
						div_steps = DIV_S_W'(RATIO_NUM_W);
						state_d   = ST_RATIO;
					end else begin
						state_d = item_q.last ? ST_FINAL : ST_IDLE;
					end
				end
			end
			ST_RATIO: begin
				if (div_done) begin
					state_d = item_q.last ? ST_FINAL : ST_IDLE;
				end
			end
			ST_FINAL: begin
				priority if (cnt_q == '0) begin
					state_d = ST_DONE;
				end else if (metric == METRIC_CHORD) begin
					state_d = ((sqa_q == '0) || (sqb_q == '0)) ? ST_DONE : ST_CH_MUL;
				end else if (metric == METRIC_CANBERRA) begin
					div_go    = 1'b1;
					div_num   = {canb_num, (DIV_N_W-CANB_NUM_W)'(0)};
					div_den   = DIV_D_W'(cnt_q);
					div_steps = DIV_S_W'(CANB_NUM_W);
					state_d   = ST_CB_DIV;
				end else if (metric == METRIC_MANHATTAN) begin
					state_d = ST_DONE;
				end else begin
					sq_go   = 1'b1;
					sq_x    = SQ_X_W'({sqd_q, 16'd0});
					state_d = ST_EU_ROOT;
				end
			end
			ST_CH_MUL: begin
				if (k_q == 3'd7) begin
					state_d = ST_CH_SQ;
				end
			end
			ST_CH_SQ: begin
				sq_go   = 1'b1;
				sq_x    = prod_q;
				state_d = ST_CH_ROOT;
			end
			ST_CH_ROOT: begin
				if (sq_done) begin
					state_d = ST_CH_DV;
				end
			end
			ST_CH_DV: begin
				div_go    = 1'b1;
				div_num   = chord_num;
				div_den   = DIV_D_W'(r_q);
				div_steps = DIV_S_W'(DIV_N_W);
				state_d   = ST_CH_DIV;
			end
			ST_CH_DIV: begin
				if (div_done) begin
					state_d = ST_CH_LAST;
				end
			end
			ST_CH_LAST: begin
				sq_go   = 1'b1;
				sq_x    = SQ_X_W'(chord_d);
				state_d = ST_CH_FIN;
			end
			ST_CH_FIN, ST_EU_ROOT: begin
				if (sq_done) begin
					state_d = ST_DONE;
				end
			end
			ST_CB_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (state_q == ST_IDLE) begin
			item_q <= item;
		end
		if (state_q == ST_FINAL) begin
			prod_q    <= '0;
			res_inv_q <= (cnt_q == '0)
			             || ((metric == METRIC_CHORD) && ((sqa_q == '0) || (sqb_q == '0)));
			res_q     <= RES_W'({abs_q, 8'd0});
		end
		if ((state_q == ST_CH_MUL) && k_q[0]) begin
			unique case (k_q[2:1])
				2'd0:    prod_q <= prod_q + SQ_X_W'(mul_q);
				2'd3:    prod_q <= prod_q + (SQ_X_W'(mul_q) << (2*MUL_W));
				default: prod_q <= prod_q + (SQ_X_W'(mul_q) << MUL_W);
			endcase
		end
		if ((state_q == ST_CH_ROOT) && sq_done) begin
			r_q <= sq_root;
		end
		if ((state_q == ST_CH_DIV) && div_done) begin
			t_q <= div_quot;
		end
		if (((state_q == ST_CH_FIN) || (state_q == ST_EU_ROOT)) && sq_done) begin
			res_q <= RES_W'(sq_root);
		end
		if ((state_q == ST_CB_DIV) && div_done) begin
			res_q <= RES_W'(div_quot);
		end
		if ((state_q == ST_DONE) && out_free) begin
			dist_q <= res_inv_q ? '0 : ((res_q > DIST_MAX) ? DIST_MAX[DIST_W-1:0]
			                                             : res_q[DIST_W-1:0]);
			inv_q  <= res_inv_q;
			sat_q  <= !res_inv_q && (res_q > DIST_MAX);
		end
	end

	// Control state and the running sums of the row pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			cross_q     <= '0;
			sqa_q       <= '0;
			sqb_q       <= '0;
			abs_q       <= '0;
			sqd_q       <= '0;
			ratio_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_PROD) || (state_q == ST_CH_MUL)) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
			if ((state_q == ST_PROD) && k_q[0]) begin
				unique case (k_q[2:1])
					2'd0: begin
						if (item_q.prod_neg) begin
							cross_q <= cross_q - $signed(mul_q);
						end else begin
							cross_q <= cross_q + $signed(mul_q);
						end
					end
					2'd1: sqa_q <= sqa_q + mul_q;
					2'd2: sqb_q <= sqb_q + mul_q;
					default: begin
						sqd_q <= sqd_q + SQD_W'(mul_q);
						abs_q <= abs_q + ABS_W'(item_q.adev);
						cnt_q <= cnt_q + 1'b1;
					end
				endcase
			end
			if ((state_q == ST_RATIO) && div_done) begin
				ratio_q <= ratio_q + RATIO_W'(div_quot);
			end
			if ((state_q == ST_DONE) && out_free) begin
				cross_q     <= '0;
				sqa_q       <= '0;
				sqb_q       <= '0;
				abs_q       <= '0;
				sqd_q       <= '0;
				ratio_q     <= '0;
				cnt_q       <= '0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;
	assign invalid   = inv_q;
	assign saturated = sat_q;

endmodule
`default_nettype wire

>>> rtl/pairwise_vector_distance_top.sv
// Top level of the pairwise vector distance block.
// Element pairs of two rows arrive one per transaction and enter a four-entry queue, so the
// input is taken while the back end works. The back end handles one pair at a time: a used
// pair passes through the shared multiplier, and then through the shared bit-serial divider
// when either value is nonzero (its Canberra ratio); a skipped pair is only popped.
// On the last pair Manhattan uses the sum directly, Euclidean takes a root (one root bit per
// cycle), Canberra a division (one quotient bit per cycle) and chord the norm product, two
// roots and a 76-bit division. The result sits in an output register, and the next row pair
// starts once it has been loaded there.
`default_nettype none
module pairwise_vector_distance_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [15:0]                value_a,
	input  wire logic [15:0]                value_b,
	input  wire logic                       a_missing,
	input  wire logic                       b_missing,
	input  wire logic                       last_element,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [pvd_pkg::DIST_W-1:0]      distance,
	output logic                            invalid,
	output logic                            saturated,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [1:0]                 metric
);
	import pvd_pkg::*;

	metric_t metric_q;
	logic    item_valid;
	item_t   item;
	logic    item_pop;

	// Metric register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_EUCLIDEAN;
		end else if (cfg_valid && cfg_ready) begin
			metric_q <= metric;
		end
	end

	pvd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value_a      (value_a),
		.value_b      (value_b),
		.a_missing    (a_missing),
		.b_missing    (b_missing),
		.last_element (last_element),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	pvd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.metric     (metric_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.distance   (distance),
		.invalid    (invalid),
		.saturated  (saturated)
	);

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the pairwise vector distance block, with its scoreboard.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: keeps its own copy of the metric and the running sums, predicts
// the distance of every row pair and compares it with what the block returns.
class distance_scoreboard;
	typedef struct {
		logic [pvd_pkg::DIST_W-1:0] distance;
		logic                       invalid;
		logic                       saturated;
	} dist_result_t;

	pvd_pkg::metric_t metric_sel;
	longint           cross_acc;
	bit [63:0]        sq_a_acc;
	bit [63:0]        sq_b_acc;
	bit [63:0]        abs_acc;
	bit [63:0]        sqd_acc;
	bit [63:0]        ratio_acc;
	int unsigned      pair_count;
	dist_result_t     pending[$];
	int               mismatches;

	function new();
		metric_sel = pvd_pkg::METRIC_EUCLIDEAN;
		mismatches = 0;
		clear_sums();
	endfunction

	function void clear_sums();
		cross_acc  = 0;
		sq_a_acc   = 0;
		sq_b_acc   = 0;
		abs_acc    = 0;
		sqd_acc    = 0;
		ratio_acc  = 0;
		pair_count = 0;
	endfunction

	// Square root rounded to nearest.
	function bit [63:0] root_nearest(bit [127:0] x);
		bit [63:0]  r;
		bit [63:0]  t;
		bit [127:0] sq;
		r = 0;
		for (int i = 62; i >= 0; i--) begin
			t  = r | (64'd1 << i);
			sq = {64'd0, t} * {64'd0, t};
			if (sq <= x) r = t;
		end
		sq = {64'd0, r} * {64'd0, r + 64'd1};
		if (x > sq) r = r + 1;
		return r;
	endfunction

	function bit [63:0] chord_value();
		bit [127:0] prod;
		bit [127:0] num;
		bit [127:0] quo;
		bit [63:0]  root;
		bit [63:0]  mag;
		bit [63:0]  d;
		prod = {64'd0, sq_a_acc} * {64'd0, sq_b_acc};
		root = root_nearest(prod);
		mag  = (cross_acc < 0) ? -cross_acc : cross_acc;
		num  = ({64'd0, mag} << 33) + {64'd0, root >> 1};
		quo  = num / {64'd0, root};
		if (cross_acc >= 0)
			d = (quo >= (128'd1 << 33)) ? 64'd0 : (64'd1 << 33) - quo[63:0];
		else
			d = (64'd1 << 33) + quo[63:0];
		return root_nearest({64'd0, d});
	endfunction

	// Accepted input transaction: update the sums and, on the last pair, predict.
	function void note_pair(logic [15:0] va, logic [15:0] vb, bit am, bit bm, bit last);
		longint       a;
		longint       b;
		longint       adev;
		longint       den;
		bit           nz;
		bit [63:0]    dist_val;
		dist_result_t res;
		a  = longint'($signed(va));
		b  = longint'($signed(vb));
		nz = (a != 0) || (b != 0);
		if (!am && !bm && (metric_sel != pvd_pkg::METRIC_CANBERRA || nz) &&
				pair_count < pvd_pkg::MAX_COLUMNS) begin
			adev = (a > b) ? a - b : b - a;
			cross_acc += a * b;
			sq_a_acc  += a * a;
			sq_b_acc  += b * b;
			abs_acc   += adev;
			sqd_acc   += adev * adev;
			if (nz) begin
				den = ((a < 0) ? -a : a) + ((b < 0) ? -b : b);
				ratio_acc += ((adev << 16) + (den >> 1)) / den;
			end
			pair_count++;
		end
		if (!last) return;
		dist_val      = 0;
		res.invalid   = 0;
		res.saturated = 0;
		if (pair_count == 0) begin
			res.invalid = 1;
		end else begin
			unique case (metric_sel)
				pvd_pkg::METRIC_CHORD: begin
					if (sq_a_acc == 0 || sq_b_acc == 0) res.invalid = 1;
					else dist_val = chord_value();
				end
				pvd_pkg::METRIC_CANBERRA:
					dist_val = (ratio_acc + (pair_count >> 1)) / pair_count;
				pvd_pkg::METRIC_MANHATTAN: dist_val = abs_acc << 8;
				default: dist_val = root_nearest({64'd0, sqd_acc} << 16);
			endcase
		end
		if (dist_val > 64'hFFFF_FFFF_FFFF) begin
			dist_val      = 64'hFFFF_FFFF_FFFF;
			res.saturated = 1;
		end
		res.distance = dist_val[pvd_pkg::DIST_W-1:0];
		pending.push_back(res);
		clear_sums();
	endfunction

	// Accepted output transaction: compare with the oldest prediction.
	function void check_result(logic [pvd_pkg::DIST_W-1:0] d, logic inv, logic sat);
		dist_result_t want;
		if (pending.size() == 0) begin
			$error("unexpected result: distance %0d invalid %0d saturated %0d", d, inv, sat);
			mismatches++;
			return;
		end
		want = pending.pop_front();
		if (d !== want.distance) begin
			$error("distance: expected %0d, actual %0d", want.distance, d);
			mismatches++;
		end
		if (inv !== want.invalid) begin
			$error("invalid: expected %0d, actual %0d", want.invalid, inv);
			mismatches++;
		end
		if (sat !== want.saturated) begin
			$error("saturated: expected %0d, actual %0d", want.saturated, sat);
			mismatches++;
		end
	endfunction
endclass

module testbench;
	import pvd_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [15:0]       value_a;
	logic [15:0]       value_b;
	logic              a_missing;
	logic              b_missing;
	logic              last_element;
	logic              out_valid;
	logic              out_stall;
	logic [DIST_W-1:0] distance;
	logic              invalid;
	logic              saturated;
	logic              cfg_valid;
	logic              cfg_ready;
	metric_t           metric;

	distance_scoreboard dist_sb;
	bit                 steady;

	pairwise_vector_distance_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.value_a(value_a), .value_b(value_b),
		.a_missing(a_missing), .b_missing(b_missing), .last_element(last_element),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .invalid(invalid), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .metric(metric)
	);

	// Clock.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: random stall, and check every accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				dist_sb.check_result(distance, invalid, saturated);
			out_stall <= !steady && ($urandom_range(99) < 24);
		end
	end

	// Sends one element pair and waits for its transaction, then maybe idles.
	task automatic send_pair(logic [15:0] va, logic [15:0] vb, bit am, bit bm, bit last);
		in_valid     <= 1;
		value_a      <= va;
		value_b      <= vb;
		a_missing    <= am;
		b_missing    <= bm;
		last_element <= last;
		do @(posedge clk); while (in_stall);
		dist_sb.note_pair(va, vb, am, bm, last);
		if (!steady && $urandom_range(99) < 24) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Waits until every predicted result has arrived and the back end has drained.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (dist_sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_metric(metric_t m);
		metric    <= m;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		dist_sb.metric_sel = m;
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return $urandom_range(1) ? 16'h0001 : 16'hFFFF;
			4: return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// One row pair of random content; some flagged missing.
	task automatic send_row(int len);
		for (int i = 0; i < len; i++)
			send_pair(rand_value(), rand_value(), $urandom_range(99) < 8,
				$urandom_range(99) < 8, i == len - 1);
	endtask

	initial begin
		int sent;
		dist_sb      = new();
		steady       = 0;
		arst_n       = 0;
		in_valid     = 0;
		value_a      = 0;
		value_b      = 0;
		a_missing    = 0;
		b_missing    = 0;
		last_element = 0;
		out_stall    = 0;
		cfg_valid    = 0;
		metric       = METRIC_EUCLIDEAN;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes under the reset metric (Euclidean).
		send_pair(16'h7FFF, 16'h8000, 0, 0, 0);
		send_pair(16'h8000, 16'h7FFF, 0, 0, 1);
		// A row with every pair missing, and a missing last pair.
		send_pair(16'h0100, 16'h0200, 1, 0, 0);
		send_pair(16'h0100, 16'h0200, 0, 1, 1);
		send_pair(16'h0300, 16'h0100, 0, 0, 0);
		send_pair(16'h0001, 16'h0002, 1, 1, 1);
		drain();
		write_metric(METRIC_MANHATTAN);
		send_pair(16'h7FFF, 16'h8000, 0, 0, 0);
		send_pair(16'h8000, 16'h7FFF, 0, 0, 1);
		drain();
		// Canberra: both-zero pairs are skipped; an all-zero row is invalid.
		write_metric(METRIC_CANBERRA);
		send_pair(16'h0000, 16'h0000, 0, 0, 0);
		send_pair(16'h0005, 16'hFFFB, 0, 0, 0);
		send_pair(16'h0000, 16'h0007, 0, 0, 1);
		send_pair(16'h0000, 16'h0000, 0, 0, 1);
		// Metric changed within a row: the zero pair is dropped under Canberra.
		send_pair(16'h0000, 16'h0000, 0, 0, 0);
		drain();
		write_metric(METRIC_EUCLIDEAN);
		send_pair(16'h0000, 16'h0000, 0, 0, 0);
		send_pair(16'h0040, 16'hFFC0, 0, 0, 1);
		drain();
		// Chord: parallel, general, zero norm, antiparallel.
		write_metric(METRIC_CHORD);
		send_pair(16'h0100, 16'h0100, 0, 0, 1);
		send_pair(16'h0100, 16'h0100, 0, 0, 0);
		send_pair(16'h0064, 16'hFED4, 0, 0, 1);
		send_pair(16'h0000, 16'h0005, 0, 0, 1);
		send_pair(16'hFF00, 16'h0100, 0, 0, 1);
		send_pair(16'h8000, 16'h8000, 0, 0, 0);
		send_pair(16'h7FFF, 16'h8000, 0, 0, 1);
		drain();

		// Random phases; one phase runs with no idling on either side.
		sent = 0;
		for (int phase = 0; sent < 1125; phase++) begin
			steady = (phase == 3);
			write_metric(metric_t'(phase < 4 ? phase : $urandom_range(3)));
			for (int n = 0; n < 100; ) begin
				int len;
				len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
				send_row(len);
				n    += len;
				sent += len;
			end
			drain();
		end
		steady = 0;

		if (dist_sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

`default_nettype wire

>>> sim.f
rtl/pvd_pkg.sv
rtl/pvd_front.sv
rtl/pvd_div.sv
rtl/pvd_sqrt.sv
rtl/pvd_back.sv
rtl/pairwise_vector_distance_top.sv
tb/testbench.sv
